>>> rtl/wind_vane_direction_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wind vane direction decoder
// Shared forms for clocked assertions, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef WIND_VANE_DIRECTION_DECODER_ASSERT_SVH
`define WIND_VANE_DIRECTION_DECODER_ASSERT_SVH

// Property checked only while the active-low reset is released.
`define WVD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, including during reset.
`define WVD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wvd_pkg.sv
// ----------------------------------------------------------------------------
// wvd_pkg
// Types, constants and the vane position table of the direction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wvd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int READ_BITS   = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
    localparam int SCALE_BITS  = READ_BITS + 4;
    localparam int CHANNELS    = 4;
    localparam int ROWS        = 16;
    localparam int DIR_BITS    = 4;

    typedef enum logic [1:0] {
        CELL_GND,
        CELL_HALF,
        CELL_TWO_THIRDS,
        CELL_FULL
    } cell_t;

    localparam int CELL_KINDS = 4;

    localparam cell_t [0:ROWS-1][0:CHANNELS-1] VANE_ROWS = '{
        '{CELL_GND,        CELL_FULL,       CELL_FULL,       CELL_FULL},
        '{CELL_GND,        CELL_GND,        CELL_FULL,       CELL_FULL},
        '{CELL_FULL,       CELL_GND,        CELL_FULL,       CELL_FULL},
        '{CELL_FULL,       CELL_GND,        CELL_GND,        CELL_FULL},
        '{CELL_FULL,       CELL_FULL,       CELL_GND,        CELL_FULL},
        '{CELL_FULL,       CELL_FULL,       CELL_GND,        CELL_GND},
        '{CELL_FULL,       CELL_FULL,       CELL_FULL,       CELL_GND},
        '{CELL_HALF,       CELL_FULL,       CELL_FULL,       CELL_GND},
        '{CELL_HALF,       CELL_FULL,       CELL_FULL,       CELL_FULL},
        '{CELL_TWO_THIRDS, CELL_TWO_THIRDS, CELL_FULL,       CELL_FULL},
        '{CELL_FULL,       CELL_HALF,       CELL_FULL,       CELL_FULL},
        '{CELL_FULL,       CELL_TWO_THIRDS, CELL_TWO_THIRDS, CELL_FULL},
        '{CELL_FULL,       CELL_FULL,       CELL_HALF,       CELL_FULL},
        '{CELL_FULL,       CELL_FULL,       CELL_TWO_THIRDS, CELL_TWO_THIRDS},
        '{CELL_FULL,       CELL_FULL,       CELL_FULL,       CELL_HALF},
        '{CELL_GND,        CELL_FULL,       CELL_FULL,       CELL_HALF}
    };

    typedef struct packed {
        logic [FIELD_BITS-1:0] channel_a;
        logic [FIELD_BITS-1:0] channel_b;
        logic [FIELD_BITS-1:0] channel_c;
        logic [FIELD_BITS-1:0] channel_d;
    } wvd_in_t;

    typedef struct packed {
        logic [DIR_BITS-1:0] direction;
        logic                matched;
    } wvd_out_t;

    typedef struct packed {
        logic [0:CHANNELS-1][READ_BITS-1:0] rd;
        logic [READ_BITS-1:0]               full;
    } max_stage_t;

    typedef struct packed {
        logic [0:CHANNELS-1][SCALE_BITS-1:0] scaled;
        logic [SCALE_BITS-1:0]               m1;
        logic [SCALE_BITS-1:0]               m5;
        logic [SCALE_BITS-1:0]               m7;
        logic [SCALE_BITS-1:0]               m9;
        logic [SCALE_BITS-1:0]               m11;
        logic [SCALE_BITS-1:0]               m13;
        logic                                nonzero;
    } scale_stage_t;

    typedef struct packed {
        logic [0:CHANNELS-1][CELL_KINDS-1:0] hit;
        logic                                nonzero;
    } cmp_stage_t;

endpackage

`default_nettype wire

>>> rtl/wind_vane_direction_decoder.sv
// ----------------------------------------------------------------------------
// wind_vane_direction_decoder
// Decodes four vane ADC readings into one of sixteen directions.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    wvd_in_t  (four readings)
//   m_        out        m_valid/m_ready    wvd_out_t (direction, matched)
//   cfg_      in         cfg_wr_en          4-bit north offset
//
// One transfer is accepted per cycle while s_ready is high; the input
// transfer loads the first of the four register stages (maximum, scaling,
// window compare, row select), and the result is held in the last.
// Reset clears the stage valid bits and the offset register to zero.
// Each stage holds its item while the next stage is full and not draining,
// so a stall on m_ready backs up into s_ready without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module wind_vane_direction_decoder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire wvd_pkg::wvd_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output wvd_pkg::wvd_out_t                 m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [wvd_pkg::DIR_BITS-1:0] cfg_wr_data
);

    logic [wvd_pkg::DIR_BITS-1:0] offset_reg;
    logic [wvd_pkg::DIR_BITS-1:0] offset_next;

    logic                  max_valid;
    logic                  max_ready;
    wvd_pkg::max_stage_t   max_data;
    logic                  scale_valid;
    logic                  scale_ready;
    wvd_pkg::scale_stage_t scale_data;
    logic                  cmp_valid;
    logic                  cmp_ready;
    wvd_pkg::cmp_stage_t   cmp_data;

    assign offset_next = cfg_wr_en ? cfg_wr_data : offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else begin
            offset_reg <= offset_next;
        end
    end

    wvd_max_stage u_max (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (max_valid),
        .out_ready (max_ready),
        .out_data  (max_data)
    );

    wvd_scale_stage u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (max_valid),
        .in_ready  (max_ready),
        .in_data   (max_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    wvd_cmp_stage u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .out_data  (cmp_data)
    );

    wvd_select_stage u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmp_valid),
        .in_ready  (cmp_ready),
        .in_data   (cmp_data),
        .offset    (offset_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/wvd_max_stage.sv
// ----------------------------------------------------------------------------
// wvd_max_stage
// Registers the masked readings together with the largest of the four.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_max_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wvd_pkg::wvd_in_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output wvd_pkg::max_stage_t     out_data
);

    logic                          valid_reg;
    logic                          valid_next;
    wvd_pkg::max_stage_t           data_reg;
    wvd_pkg::max_stage_t           data_next;
    logic [wvd_pkg::READ_BITS-1:0] max_ab;
    logic [wvd_pkg::READ_BITS-1:0] max_cd;

    always_comb begin
        data_next.rd[0] = in_data.channel_a[wvd_pkg::READ_BITS-1:0];
        data_next.rd[1] = in_data.channel_b[wvd_pkg::READ_BITS-1:0];
        data_next.rd[2] = in_data.channel_c[wvd_pkg::READ_BITS-1:0];
        data_next.rd[3] = in_data.channel_d[wvd_pkg::READ_BITS-1:0];
        max_ab = (data_next.rd[0] > data_next.rd[1]) ? data_next.rd[0] : data_next.rd[1];
        max_cd = (data_next.rd[2] > data_next.rd[3]) ? data_next.rd[2] : data_next.rd[3];
        data_next.full = (max_ab > max_cd) ? max_ab : max_cd;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/wvd_scale_stage.sv
// ----------------------------------------------------------------------------
// wvd_scale_stage
// Forms twelve times each reading and the odd multiples of full scale that
// bound the tolerance windows.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_scale_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wvd_pkg::max_stage_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wvd_pkg::scale_stage_t     out_data
);

    logic                           valid_reg;
    logic                           valid_next;
    wvd_pkg::scale_stage_t          data_reg;
    wvd_pkg::scale_stage_t          data_next;
    logic [wvd_pkg::SCALE_BITS-1:0] m;
    logic [wvd_pkg::SCALE_BITS-1:0] a;

    always_comb begin
        m = wvd_pkg::SCALE_BITS'(in_data.full);
        for (int i = 0; i < wvd_pkg::CHANNELS; i++) begin
            a = wvd_pkg::SCALE_BITS'(in_data.rd[i]);
            data_next.scaled[i] = (a << 3) + (a << 2);
        end
        data_next.m1      = m;
        data_next.m5      = (m << 2) + m;
        data_next.m7      = (m << 3) - m;
        data_next.m9      = (m << 3) + m;
        data_next.m11     = (m << 3) + (m << 1) + m;
        data_next.m13     = (m << 3) + (m << 2) + m;
        data_next.nonzero = |in_data.full;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/wvd_cmp_stage.sv
// ----------------------------------------------------------------------------
// wvd_cmp_stage
// Tests every reading against the tolerance window of each cell level.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_cmp_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire wvd_pkg::scale_stage_t  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output wvd_pkg::cmp_stage_t         out_data
);

    logic                           valid_reg;
    logic                           valid_next;
    wvd_pkg::cmp_stage_t            data_reg;
    wvd_pkg::cmp_stage_t            data_next;
    logic [wvd_pkg::SCALE_BITS-1:0] s;

    always_comb begin
        for (int i = 0; i < wvd_pkg::CHANNELS; i++) begin
            s = in_data.scaled[i];
            data_next.hit[i][wvd_pkg::CELL_GND]        = (s <= in_data.m1);
            data_next.hit[i][wvd_pkg::CELL_HALF]       = (s >= in_data.m5)
                                                         && (s <= in_data.m7);
            data_next.hit[i][wvd_pkg::CELL_TWO_THIRDS] = (s >= in_data.m7)
                                                         && (s <= in_data.m9);
            data_next.hit[i][wvd_pkg::CELL_FULL]       = (s >= in_data.m11)
                                                         && (s <= in_data.m13);
        end
        data_next.nonzero = in_data.nonzero;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/wvd_select_stage.sv
// ----------------------------------------------------------------------------
// wvd_select_stage
// Picks the first table row whose four cells all match and applies the
// north offset; this register is the output register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module wvd_select_stage (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire wvd_pkg::cmp_stage_t          in_data,
    input  wire logic [wvd_pkg::DIR_BITS-1:0] offset,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output wvd_pkg::wvd_out_t                 out_data
);

    logic                         valid_reg;
    logic                         valid_next;
    wvd_pkg::wvd_out_t            data_reg;
    wvd_pkg::wvd_out_t            data_next;
    logic [wvd_pkg::ROWS-1:0]     row_ok;
    logic [wvd_pkg::DIR_BITS-1:0] row_sel;
    logic                         any_hit;

    always_comb begin
        for (int r = 0; r < wvd_pkg::ROWS; r++) begin
            row_ok[r] = in_data.nonzero;
            for (int i = 0; i < wvd_pkg::CHANNELS; i++) begin
                row_ok[r] = row_ok[r] && in_data.hit[i][wvd_pkg::VANE_ROWS[r][i]];
            end
        end
        any_hit = 1'b0;
        row_sel = '0;
        for (int r = wvd_pkg::ROWS - 1; r >= 0; r--) begin
            if (row_ok[r]) begin
                any_hit = 1'b1;
                row_sel = wvd_pkg::DIR_BITS'(r);
            end
        end
        data_next.matched   = any_hit;
        data_next.direction = any_hit ? (row_sel - offset) : '0;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/wvd_checker.sv
// ----------------------------------------------------------------------------
// wvd_checker
// Port-level checks on the direction decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wind_vane_direction_decoder_assert.svh"

module wvd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire wvd_pkg::wvd_out_t m_data
);

    logic stalled;
    logic bad_dir;

    assign stalled = m_valid && !m_ready;
    assign bad_dir = m_valid && !m_data.matched && (m_data.direction != '0);

    `WVD_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `WVD_ASSERT(a_unmatched_zero, aclk, aresetn, !bad_dir, "unmatched result with direction")
    `WVD_ASSERT(a_out_hold, aclk, aresetn, stalled |=> m_valid, "stalled result dropped")
    `WVD_ASSERT(a_out_stable, aclk, aresetn, stalled |=> $stable(m_data), "stalled result changed")

endmodule

bind wind_vane_direction_decoder wvd_checker u_wvd_checker (.*);

`default_nettype wire
